/* sv/sceq_pkg.sv */
// ----------------------------------------------------------------------------
// sceq_pkg
// Shared constants, micro-instruction type and sequencer decode for the
// stereo channel equaliser.
// ----------------------------------------------------------------------------
package sceq_pkg;

    // default widths
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COEF_WIDTH_DEF   = 32;
    localparam int DELAY_WIDTH_DEF  = 48;

    // store sizes
    localparam int NUM_COEFS    = 33;
    localparam int NUM_DELAYS   = 26;
    localparam int NUM_SECTIONS = 6;

    // mix unity and smoothing reset
    localparam logic [16:0] MIX_ONE    = 17'd65536;
    localparam logic [16:0] SMOOTH_RST = 17'd99;

    // configuration register indexes
    localparam logic [1:0] CFG_HP_EN  = 2'd0;
    localparam logic [1:0] CFG_LP_EN  = 2'd1;
    localparam logic [1:0] CFG_MONO   = 2'd2;
    localparam logic [1:0] CFG_SMOOTH = 2'd3;

    // input item kinds
    localparam logic OPN_SAMPLE = 1'b0;
    localparam logic OPN_COEF   = 1'b1;

    // micro-instruction kinds
    localparam logic [3:0] K_MULX   = 4'd0;  // acc op= coef * x
    localparam logic [3:0] K_MULY   = 4'd1;  // acc op= coef * y
    localparam logic [3:0] K_ADDD   = 4'd2;  // acc += delay word
    localparam logic [3:0] K_STD    = 4'd3;  // delay word = acc
    localparam logic [3:0] K_STY    = 4'd4;  // y = acc
    localparam logic [3:0] K_STX    = 4'd5;  // x = acc
    localparam logic [3:0] K_MOVYX  = 4'd6;  // x = y, flag: dry = y too
    localparam logic [3:0] K_XFSUB  = 4'd7;  // acc = y - dry
    localparam logic [3:0] K_XFMUL  = 4'd8;  // acc = dry + acc * mix
    localparam logic [3:0] K_OUT    = 4'd9;  // channel result = acc
    localparam logic [3:0] K_LOADIN = 4'd10; // x = dry = channel input
    localparam logic [3:0] K_EASE   = 4'd11; // ease one mix
    localparam logic [3:0] K_NEXT   = 4'd12; // next section

    // accumulate ops
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SUB  = 1'b1;

    // section codes
    localparam logic [2:0] SEC_FO   = 3'd0;
    localparam logic [2:0] SEC_HPBQ = 3'd1;
    localparam logic [2:0] SEC_HSH  = 3'd5;
    localparam logic [2:0] SEC_LPBQ = 3'd6;
    localparam logic [2:0] SEC_PRO  = 3'd7;

    typedef struct packed {
        logic [3:0] kind;
        logic       op;
        logic [5:0] cidx;
        logic [4:0] didx;
        logic       flag;  // mix select or dry update
    } t_instr;

    function automatic t_instr f_mk(logic [3:0] kind, logic op, int cidx, int didx,
                                    logic flag);
        t_instr r;
        r.kind = kind;
        r.op   = op;
        r.cidx = 6'(cidx);
        r.didx = 5'(didx);
        r.flag = flag;
        return r;
    endfunction

    // program of one channel: prologue, first order, six biquads with tails
    function automatic t_instr f_decode(logic [2:0] sec, logic [3:0] sub, logic ch);
        t_instr r;
        int     s;
        int     c;
        int     d;
        s = int'(sec) - 1;
        c = 3 + 5 * s;
        d = 2 + 4 * s + 2 * int'(ch);
        r = f_mk(K_NEXT, OP_LOAD, 0, 0, 1'b0);
        if (sec == SEC_PRO) begin
            if (sub == 4'd0) r = f_mk(K_EASE, OP_LOAD, 0, 0, 1'b0);
            else if (sub == 4'd1) r = f_mk(K_EASE, OP_LOAD, 0, 0, 1'b1);
        end else if (sec == SEC_FO) begin
            unique case (sub)
                4'd0: r = f_mk(K_LOADIN, OP_LOAD, 0, 0, 1'b0);
                4'd1: r = f_mk(K_MULX, OP_LOAD, 0, 0, 1'b0);
                4'd2: r = f_mk(K_ADDD, OP_LOAD, 0, int'(ch), 1'b0);
                4'd3: r = f_mk(K_STY, OP_LOAD, 0, 0, 1'b0);
                4'd4: r = f_mk(K_MULX, OP_LOAD, 1, 0, 1'b0);
                4'd5: r = f_mk(K_MULY, OP_SUB, 2, 0, 1'b0);
                4'd6: r = f_mk(K_STD, OP_LOAD, 0, int'(ch), 1'b0);
                4'd7: r = f_mk(K_MOVYX, OP_LOAD, 0, 0, 1'b0);
                default: r = f_mk(K_NEXT, OP_LOAD, 0, 0, 1'b0);
            endcase
        end else begin
            unique case (sub)
                4'd0: r = f_mk(K_MULX, OP_LOAD, c, 0, 1'b0);
                4'd1: r = f_mk(K_ADDD, OP_LOAD, 0, d, 1'b0);
                4'd2: r = f_mk(K_STY, OP_LOAD, 0, 0, 1'b0);
                4'd3: r = f_mk(K_MULX, OP_LOAD, c + 1, 0, 1'b0);
                4'd4: r = f_mk(K_MULY, OP_SUB, c + 3, 0, 1'b0);
                4'd5: r = f_mk(K_ADDD, OP_LOAD, 0, d + 1, 1'b0);
                4'd6: r = f_mk(K_STD, OP_LOAD, 0, d, 1'b0);
                4'd7: r = f_mk(K_MULX, OP_LOAD, c + 2, 0, 1'b0);
                4'd8: r = f_mk(K_MULY, OP_SUB, c + 4, 0, 1'b0);
                4'd9: r = f_mk(K_STD, OP_LOAD, 0, d + 1, 1'b0);
                4'd10: begin
                    if (sec == SEC_HPBQ || sec == SEC_LPBQ)
                        r = f_mk(K_XFSUB, OP_LOAD, 0, 0, 1'b0);
                    else
                        r = f_mk(K_MOVYX, OP_LOAD, 0, 0, sec == SEC_HSH);
                end
                4'd11: begin
                    if (sec == SEC_HPBQ || sec == SEC_LPBQ)
                        r = f_mk(K_XFMUL, OP_LOAD, 0, 0, sec == SEC_LPBQ);
                    else
                        r = f_mk(K_NEXT, OP_LOAD, 0, 0, 1'b0);
                end
                4'd12: begin
                    if (sec == SEC_HPBQ) r = f_mk(K_STX, OP_LOAD, 0, 0, 1'b0);
                    else if (sec == SEC_LPBQ) r = f_mk(K_OUT, OP_LOAD, 0, 0, 1'b0);
                    else r = f_mk(K_NEXT, OP_LOAD, 0, 0, 1'b0);
                end
                default: r = f_mk(K_NEXT, OP_LOAD, 0, 0, 1'b0);
            endcase
        end
        return r;
    endfunction

    // store entries that hold a b0 coefficient
    function automatic logic f_is_b0(logic [5:0] idx);
        logic r;
        r = (idx == 6'd0);
        for (int s = 0; s < NUM_SECTIONS; s++) begin
            if (idx == 6'(3 + 5 * s)) r = 1'b1;
        end
        return r;
    endfunction

endpackage

/* sv/stereo_channel_eq_cascade.sv */
// ----------------------------------------------------------------------------
// stereo_channel_eq_cascade
// Stereo channel equaliser: first-order and biquad high-pass, four shaping
// biquads and a biquad low-pass, with eased crossfades, on one shared
// multiplier under a micro-sequencer.
// ----------------------------------------------------------------------------
// sequence: a sample request first eases the two mixes and takes one step,
// then runs per channel 35 multiplies on the shared multiplier and 50
// other steps, and finally hands the pair over to the output register
// requests: sample and coefficient requests are accepted only while idle, so
// a new sample waits until the last pair has been handed over
// reset: synchronous active low; coefficient valid bits, delay words, mixes
// and control are cleared, registers return to their reset values
module stereo_channel_eq_cascade #(
    parameter int SAMPLE_WIDTH = sceq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = sceq_pkg::COEF_WIDTH_DEF,
    parameter int DELAY_WIDTH  = sceq_pkg::DELAY_WIDTH_DEF,
    localparam int DIN_W  = ((2 * SAMPLE_WIDTH + 6 + COEF_WIDTH + 7) / 8) * 8,
    localparam int DOUT_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // left_sample, right_sample, coef_index, coef_value, zero fill
    input  logic [DIN_W-1:0]  s_tdata,
    // operation
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // left_out, right_out, zero fill
    output logic [DOUT_W-1:0] m_tdata,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [16:0]       i_cfg_data
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = COEF_WIDTH;
    localparam int DW = DELAY_WIDTH;
    localparam int SS = (DW > SW) ? ((DW - SW) / 2) : 0;
    localparam int CF = CW - 5;
    localparam int HW = (DW + 1) / 2;
    localparam int PW = DW + CW;
    localparam int RW = PW + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_MAG  = 3'd2;
    localparam logic [2:0] S_M0   = 3'd3;
    localparam logic [2:0] S_M1   = 3'd4;
    localparam logic [2:0] S_RND  = 3'd5;
    localparam logic [2:0] S_ACC  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [RW-1:0] LIM_P = {{(RW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [RW-1:0] LIM_N = LIM_P + RW'(1);
    localparam logic [DW+1:0] SMAX  = {{(DW+3-SW){1'b0}}, {(SW-1){1'b1}}};
    localparam logic [DW+1:0] SMINM = SMAX + (DW+2)'(1);

    // saturating add or subtract
    function automatic logic signed [DW-1:0] f_sat(logic signed [DW-1:0] a,
                                                   logic signed [DW-1:0] b, logic sub);
        logic signed [DW:0] s;
        s = sub ? ($signed({a[DW-1], a}) - $signed({b[DW-1], b}))
                : ($signed({a[DW-1], a}) + $signed({b[DW-1], b}));
        if (s[DW] != s[DW-1]) return s[DW] ? DMIN : DMAX;
        return s[DW-1:0];
    endfunction

    // rounded and saturated output sample
    function automatic logic [SW-1:0] f_sout(logic signed [DW-1:0] v);
        logic [DW-1:0] m;
        logic [DW+1:0] r;
        m = v[DW-1] ? (~v + DW'(1)) : v;
        r = ({1'b0, m, 1'b0} + ((DW+2)'(1) << SS)) >> (SS + 1);
        if (v[DW-1]) begin
            if (r > SMINM) return {1'b1, {(SW-1){1'b0}}};
            return ~r[SW-1:0] + SW'(1);
        end
        if (r > SMAX) return {1'b0, {(SW-1){1'b1}}};
        return r[SW-1:0];
    endfunction

    // reset contents of the coefficient store
    function automatic logic signed [CW-1:0] f_coef_rst(logic [5:0] idx);
        logic signed [CW-1:0] one;
        one = CW'(1) << CF;
        if (sceq_pkg::f_is_b0(idx)) return one;
        if (idx == 6'd1) return -one;
        return '0;
    endfunction

    // configuration
    logic        r_hp_en, r_lp_en, r_mono;
    logic [16:0] r_smooth;

    // control
    logic [2:0] r_state;
    logic [2:0] r_sec;
    logic [3:0] r_sub;
    logic       r_ch;
    logic       r_seen;
    logic       r_ovalid;
    sceq_pkg::t_instr r_ins;
    sceq_pkg::t_instr w_ins;

    // datapath
    logic [SW-1:0]          r_in_l, r_in_r;
    logic signed [DW-1:0]   r_x, r_y, r_dry, r_acc, r_a, r_p;
    logic signed [DW-1:0]   r_dly [sceq_pkg::NUM_DELAYS];
    logic [16:0]            r_hp_mix, r_lp_mix;
    logic [SW-1:0]          r_res_l, r_res_r;
    logic [DOUT_W-1:0]      r_odata;

    // coefficient store
    logic signed [CW-1:0]   r_cmem [sceq_pkg::NUM_COEFS];
    logic [sceq_pkg::NUM_COEFS-1:0] r_cvalid;
    logic signed [CW-1:0]   r_cdat;
    logic                   r_cvld;
    logic [5:0]             r_cidx;

    // multiplier
    logic [DW-1:0] r_ua;
    logic [CW-1:0] r_ub;
    logic          r_neg;
    logic          r_sh16;
    logic [PW-1:0] r_prod;

    logic                   w_s_acc, w_coef_wr;
    logic [5:0]             w_wr_idx;
    logic signed [CW-1:0]   w_wr_val;
    logic [16:0]            w_k;
    logic [16:0]            w_mix;
    logic                   w_en;
    logic signed [17:0]     w_delta;
    logic signed [17:0]     w_step;
    logic signed [17:0]     w_mix_new;
    logic signed [CW-1:0]   w_b;
    logic signed [CW-1:0]   w_coef;
    logic [HW+CW-1:0]       w_plo;
    logic [PW-HW-1:0]       w_phi;
    logic [RW-1:0]          w_rx, w_rs, w_lim, w_mg;
    logic signed [DW-1:0]   w_pv;
    logic [SW-1:0]          w_chin;
    logic signed [DW-1:0]   w_chin_d;

    // handshake and request fields
    assign s_tready    = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign m_tvalid    = r_ovalid;
    assign m_tdata     = r_odata;
    assign w_s_acc     = s_tvalid && s_tready;
    assign w_coef_wr   = w_s_acc && (s_tuser == sceq_pkg::OPN_COEF) &&
                         (s_tdata[2*SW +: 6] < 6'(sceq_pkg::NUM_COEFS));
    assign w_wr_idx    = s_tdata[2*SW +: 6];
    assign w_wr_val    = s_tdata[2*SW+6 +: CW];

    // current micro-instruction
    assign w_ins = sceq_pkg::f_decode(r_sec, r_sub, r_ch);

    // easing terms for the mix picked by the flag
    assign w_k       = (r_smooth > sceq_pkg::MIX_ONE) ? sceq_pkg::MIX_ONE : r_smooth;
    assign w_mix     = r_ins.flag ? r_lp_mix : r_hp_mix;
    assign w_en      = w_ins.flag ? r_lp_en : r_hp_en;
    assign w_delta   = (w_en ? 18'sd65536 : 18'sd0) -
                       $signed({1'b0, (w_ins.flag ? r_lp_mix : r_hp_mix)});
    assign w_step    = (r_p == '0 && $signed({1'b0, w_mix}) !=
                        ((r_ins.flag ? r_lp_en : r_hp_en) ? 18'sd65536 : 18'sd0) &&
                        w_k != 17'd0)
                       ? (((r_ins.flag ? r_lp_en : r_hp_en)) ? 18'sd1 : -18'sd1)
                       : r_p[17:0];
    assign w_mix_new = $signed({1'b0, w_mix}) + w_step;

    // second operand of the shared multiplier
    assign w_coef = r_cvld ? r_cdat : f_coef_rst(r_cidx);
    always_comb begin
        unique case (r_ins.kind)
            sceq_pkg::K_MULX, sceq_pkg::K_MULY: w_b = w_coef;
            sceq_pkg::K_XFMUL: w_b = CW'($signed({1'b0, w_mix}));
            default: w_b = CW'($signed({1'b0, w_k}));
        endcase
    end

    // partial products, rounding and saturation
    assign w_plo = r_ua[HW-1:0] * r_ub;
    assign w_phi = r_ua[DW-1:HW] * r_ub;
    assign w_rx  = {1'b0, r_prod, 1'b0} + (r_sh16 ? (RW'(1) << 16) : (RW'(1) << CF));
    assign w_rs  = r_sh16 ? (w_rx >> 17) : (w_rx >> (CF + 1));
    assign w_lim = r_neg ? LIM_N : LIM_P;
    assign w_mg  = (w_rs > w_lim) ? w_lim : w_rs;
    assign w_pv  = r_neg ? -$signed(w_mg[DW-1:0]) : $signed(w_mg[DW-1:0]);

    // channel input, scaled up to the internal format
    assign w_chin   = (r_ch && !r_mono) ? r_in_r : r_in_l;
    assign w_chin_d = DW'($signed(w_chin)) <<< SS;

    // coefficient store
    always_ff @(posedge i_clk) begin
        if (w_coef_wr) r_cmem[w_wr_idx] <= w_wr_val;
        r_cdat <= r_cmem[w_ins.cidx];
        r_cidx <= w_ins.cidx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
            r_cvld   <= 1'b0;
        end else begin
            if (w_coef_wr) r_cvalid[w_wr_idx] <= 1'b1;
            r_cvld <= r_cvalid[w_ins.cidx];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp_en  <= 1'b0;
            r_lp_en  <= 1'b0;
            r_mono   <= 1'b0;
            r_smooth <= sceq_pkg::SMOOTH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sceq_pkg::CFG_HP_EN:  r_hp_en  <= i_cfg_data[0];
                sceq_pkg::CFG_LP_EN:  r_lp_en  <= i_cfg_data[0];
                sceq_pkg::CFG_MONO:   r_mono   <= i_cfg_data[0];
                sceq_pkg::CFG_SMOOTH: r_smooth <= i_cfg_data;
            endcase
        end
    end

    // multiplier datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MAG: begin
                r_ua   <= r_a[DW-1] ? (~r_a + DW'(1)) : r_a;
                r_ub   <= w_b[CW-1] ? (~w_b + CW'(1)) : w_b;
                r_neg  <= r_a[DW-1] ^ w_b[CW-1];
                r_sh16 <= !(r_ins.kind == sceq_pkg::K_MULX ||
                            r_ins.kind == sceq_pkg::K_MULY);
            end
            S_M0:  r_prod <= {{(PW-HW-CW){1'b0}}, w_plo};
            S_M1:  r_prod <= r_prod + {w_phi, {HW{1'b0}}};
            S_RND: r_p <= w_pv;
            default: ;
        endcase
    end

    // sequencer and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sec    <= sceq_pkg::SEC_PRO;
            r_sub    <= '0;
            r_ch     <= 1'b0;
            r_seen   <= 1'b0;
            r_ovalid <= 1'b0;
            r_hp_mix <= '0;
            r_lp_mix <= '0;
            for (int i = 0; i < sceq_pkg::NUM_DELAYS; i++) r_dly[i] <= '0;
        end else begin
            if (r_ovalid && m_tready && r_state != S_DONE) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_s_acc && s_tuser == sceq_pkg::OPN_SAMPLE) begin
                        r_in_l  <= s_tdata[SW-1:0];
                        r_in_r  <= s_tdata[2*SW-1:SW];
                        r_state <= S_DEC;
                        r_sec   <= sceq_pkg::SEC_PRO;
                        r_sub   <= '0;
                        r_ch    <= 1'b0;
                        // first sample snaps both mixes
                        if (!r_seen) begin
                            r_hp_mix <= r_hp_en ? sceq_pkg::MIX_ONE : 17'd0;
                            r_lp_mix <= r_lp_en ? sceq_pkg::MIX_ONE : 17'd0;
                            r_seen   <= 1'b1;
                        end
                    end
                end
                S_DEC: begin
                    r_ins <= w_ins;
                    r_sub <= (w_ins.kind == sceq_pkg::K_NEXT) ? 4'd0 : r_sub + 4'd1;
                    unique case (w_ins.kind)
                        sceq_pkg::K_MULX: begin
                            r_a <= r_x;
                            r_state <= S_MAG;
                        end
                        sceq_pkg::K_MULY: begin
                            r_a <= r_y;
                            r_state <= S_MAG;
                        end
                        sceq_pkg::K_XFMUL: begin
                            r_a <= r_acc;
                            r_state <= S_MAG;
                        end
                        sceq_pkg::K_EASE: begin
                            r_a <= DW'(w_delta);
                            r_state <= S_MAG;
                        end
                        sceq_pkg::K_ADDD: r_acc <= f_sat(r_acc, r_dly[w_ins.didx], 1'b0);
                        sceq_pkg::K_STD:  r_dly[w_ins.didx] <= r_acc;
                        sceq_pkg::K_STY:  r_y <= r_acc;
                        sceq_pkg::K_STX:  r_x <= r_acc;
                        sceq_pkg::K_MOVYX: begin
                            r_x <= r_y;
                            if (w_ins.flag) r_dry <= r_y;
                        end
                        sceq_pkg::K_XFSUB: r_acc <= f_sat(r_y, r_dry, 1'b1);
                        sceq_pkg::K_OUT: begin
                            if (r_ch) r_res_r <= f_sout(r_acc);
                            else r_res_l <= f_sout(r_acc);
                        end
                        sceq_pkg::K_LOADIN: begin
                            r_x   <= w_chin_d;
                            r_dry <= w_chin_d;
                        end
                        default: begin
                            // next section, next channel or finish
                            priority if (r_sec == sceq_pkg::SEC_PRO) begin
                                r_sec <= sceq_pkg::SEC_FO;
                            end else if (r_sec == sceq_pkg::SEC_LPBQ) begin
                                r_sec <= sceq_pkg::SEC_FO;
                                if (r_ch) r_state <= S_DONE;
                                else r_ch <= 1'b1;
                            end else begin
                                r_sec <= r_sec + 3'd1;
                            end
                        end
                    endcase
                end
                S_MAG: r_state <= S_M0;
                S_M0:  r_state <= S_M1;
                S_M1:  r_state <= S_RND;
                S_RND: r_state <= S_ACC;
                S_ACC: begin
                    r_state <= S_DEC;
                    unique case (r_ins.kind)
                        sceq_pkg::K_MULX, sceq_pkg::K_MULY: begin
                            if (r_ins.op == sceq_pkg::OP_SUB) r_acc <= f_sat(r_acc, r_p, 1'b1);
                            else r_acc <= r_p;
                        end
                        sceq_pkg::K_XFMUL: r_acc <= f_sat(r_dry, r_p, 1'b0);
                        default: begin
                            if (r_ins.flag) r_lp_mix <= w_mix_new[16:0];
                            else r_hp_mix <= w_mix_new[16:0];
                        end
                    endcase
                end
                default: begin
                    // hand the pair to the output register
                    if (!r_ovalid || m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= DOUT_W'({r_res_r, r_res_l});
                        r_state  <= S_IDLE;
                        r_ch     <= 1'b0;
                    end
                end
            endcase
        end
    end

    // multiplier steps run in a fixed order
    a_mul_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M0) |=> (r_state == S_M1))
        else $error("multiplier step order broken");

    // a sample request starts the sequencer
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && s_tuser == sceq_pkg::OPN_SAMPLE) |=> (r_state == S_DEC))
        else $error("sample request did not start processing");

    // mixes stay within unity
    a_mix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hp_mix <= sceq_pkg::MIX_ONE) && (r_lp_mix <= sceq_pkg::MIX_ONE))
        else $error("mix out of range");

    // result only leaves the finishing state into idle
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_ovalid || m_tready)) |=> (r_state == S_IDLE && r_ovalid))
        else $error("result hand-over lost");

endmodule

/* tb/stereo_channel_eq_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_channel_eq_checker
// Watches the sample, result and register channels of the stereo channel
// equaliser. It keeps its own fixed-point copy of the filter cascade and
// compares every returned stereo pair against the oldest pending prediction.
// ----------------------------------------------------------------------------
module stereo_channel_eq_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [87:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    output int          o_pending,
    output int          o_errors
);

    localparam int     SIG_SHIFT = 12;
    localparam int     COEF_FRAC = 27;
    localparam longint DMAX      = (64'sd1 <<< 47) - 1;
    localparam longint SMAX      = (64'sd1 <<< 23) - 1;
    localparam longint UNITY     = 64'sd65536;

    typedef struct {
        logic [23:0] left;
        logic [23:0] right;
    } t_stereo_pair;

    t_stereo_pair eq_out_q[$];

    // equaliser state
    longint coefs[sceq_pkg::NUM_COEFS];
    longint delays[sceq_pkg::NUM_DELAYS];
    longint hp_mix;
    longint lp_mix;
    bit     started;
    bit     hp_en;
    bit     lp_en;
    bit     mono;
    longint smoothing;

    function automatic longint clamp_d(logic signed [127:0] v);
        if (v > DMAX) return DMAX;
        if (v < -DMAX - 1) return -DMAX - 1;
        return longint'(v);
    endfunction

    function automatic longint add_d(longint a, longint b);
        logic signed [127:0] t;
        t = a;
        t = t + b;
        return clamp_d(t);
    endfunction

    function automatic longint sub_d(longint a, longint b);
        logic signed [127:0] t;
        t = a;
        t = t - b;
        return clamp_d(t);
    endfunction

    // product shifted down, rounded half away from zero, saturated
    function automatic longint mul_round(longint a, longint b, int sh);
        logic signed [127:0] p;
        logic signed [127:0] bb;
        logic [127:0]        m;
        bit                  neg;
        p   = a;
        bb  = b;
        p   = p * bb;
        neg = p < 0;
        m   = neg ? -p : p;
        m   = (m + (128'd1 << (sh - 1))) >> sh;
        if (neg) return (m > DMAX + 1) ? -DMAX - 1 : -longint'(m);
        return (m > DMAX) ? DMAX : longint'(m);
    endfunction

    function automatic longint cmul(longint x, int idx);
        return mul_round(coefs[idx], x, COEF_FRAC);
    endfunction

    function automatic longint to_internal(logic [23:0] raw);
        longint v;
        v = longint'(signed'(raw));
        return v <<< SIG_SHIFT;
    endfunction

    function automatic logic [23:0] to_sample(longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (SIG_SHIFT - 1))) >>> SIG_SHIFT;
        if (v < 0) return (m > SMAX + 1) ? 24'h800000 : 24'(-m);
        return (m > SMAX) ? 24'h7fffff : 24'(m);
    endfunction

    function automatic longint ease_mix(longint mix, bit en);
        longint tgt;
        longint k;
        longint delta;
        longint prod;
        longint m;
        longint stp;
        tgt   = en ? UNITY : 0;
        k     = (smoothing > UNITY) ? UNITY : smoothing;
        delta = tgt - mix;
        prod  = k * delta;
        m     = (((prod < 0) ? -prod : prod) + 32768) >>> 16;
        stp   = (prod < 0) ? -m : m;
        if (stp == 0 && delta != 0 && k != 0) stp = (delta > 0) ? 1 : -1;
        return mix + stp;
    endfunction

    function automatic longint run_biquad(longint x, int s, int ch);
        int     c;
        int     d;
        longint y;
        c = 3 + 5 * s;
        d = 2 + 4 * s + 2 * ch;
        y = add_d(cmul(x, c), delays[d]);
        delays[d] = add_d(sub_d(cmul(x, c + 1), cmul(y, c + 3)), delays[d + 1]);
        delays[d + 1] = sub_d(cmul(x, c + 2), cmul(y, c + 4));
        return y;
    endfunction

    function automatic longint blend(longint dry, longint wet, longint mix);
        return add_d(dry, mul_round(sub_d(wet, dry), mix, 16));
    endfunction

    // one channel through the whole cascade
    function automatic longint equalise(longint x, int ch);
        longint f;
        f = add_d(cmul(x, 0), delays[ch]);
        delays[ch] = sub_d(cmul(x, 1), cmul(f, 2));
        f = run_biquad(f, 0, ch);
        x = blend(x, f, hp_mix);
        for (int s = 1; s < sceq_pkg::NUM_SECTIONS - 1; s++) x = run_biquad(x, s, ch);
        f = run_biquad(x, sceq_pkg::NUM_SECTIONS - 1, ch);
        return blend(x, f, lp_mix);
    endfunction

    task automatic clear_state();
        foreach (delays[i]) delays[i] = 0;
        foreach (coefs[i]) coefs[i] = 0;
        coefs[0] = 64'sd1 <<< COEF_FRAC;
        coefs[1] = -(64'sd1 <<< COEF_FRAC);
        for (int s = 0; s < sceq_pkg::NUM_SECTIONS; s++)
            coefs[3 + 5 * s] = 64'sd1 <<< COEF_FRAC;
        hp_mix    = 0;
        lp_mix    = 0;
        started   = 0;
        hp_en     = 0;
        lp_en     = 0;
        mono      = 0;
        smoothing = sceq_pkg::SMOOTH_RST;
        eq_out_q.delete();
    endtask

    task automatic predict_sample(logic [87:0] d);
        longint       l;
        longint       r;
        t_stereo_pair p;
        if (!started) begin
            hp_mix  = hp_en ? UNITY : 0;
            lp_mix  = lp_en ? UNITY : 0;
            started = 1;
        end
        hp_mix = ease_mix(hp_mix, hp_en);
        lp_mix = ease_mix(lp_mix, lp_en);
        l = to_internal(d[23:0]);
        r = mono ? l : to_internal(d[47:24]);
        p.left  = to_sample(equalise(l, 0));
        p.right = to_sample(equalise(r, 1));
        eq_out_q.push_back(p);
    endtask

    task automatic note_mismatch(string what, logic [23:0] want, logic [23:0] got);
        if (o_errors < 10)
            $display("%0t mismatch %s: expected %h actual %h", $realtime, what, want, got);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_stereo_pair want;
        if (!i_rst_n) begin
            clear_state();
            o_errors = 0;
        end else begin
            // returned pair against oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                if (eq_out_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t unexpected result %h", $realtime, i_m_tdata);
                    o_errors++;
                end else begin
                    want = eq_out_q.pop_front();
                    if (want.left !== i_m_tdata[23:0])
                        note_mismatch("left", want.left, i_m_tdata[23:0]);
                    if (want.right !== i_m_tdata[47:24])
                        note_mismatch("right", want.right, i_m_tdata[47:24]);
                end
            end
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    sceq_pkg::CFG_HP_EN:  hp_en = i_cfg_data[0];
                    sceq_pkg::CFG_LP_EN:  lp_en = i_cfg_data[0];
                    sceq_pkg::CFG_MONO:   mono = i_cfg_data[0];
                    sceq_pkg::CFG_SMOOTH: smoothing = longint'(i_cfg_data);
                    default: ;
                endcase
            end
            // incoming requests
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == sceq_pkg::OPN_COEF) begin
                    if (i_s_tdata[53:48] < sceq_pkg::NUM_COEFS)
                        coefs[i_s_tdata[53:48]] = longint'(signed'(i_s_tdata[85:54]));
                end else begin
                    predict_sample(i_s_tdata);
                end
            end
        end
        o_pending = eq_out_q.size();
    end

endmodule

/* tb/stereo_channel_eq_cascade_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_channel_eq_cascade_test
// Drives sample and coefficient requests into the stereo channel equaliser
// through several register settings, with random gaps and output stalls; a
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module stereo_channel_eq_cascade_test;

    localparam int SETTLE = 700;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [16:0] i_cfg_data;
    int          pending;
    int          errors;
    bit          no_gaps;

    stereo_channel_eq_cascade dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    stereo_channel_eq_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_pending(pending), .o_errors(errors)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

    // one request on the sample channel, valid held between back-to-back requests
    task automatic push_request(logic op, logic [23:0] l, logic [23:0] r,
                                logic [5:0] idx, logic [31:0] val);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, val, idx, r, l};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic send_sample(logic [23:0] l, logic [23:0] r);
        push_request(sceq_pkg::OPN_SAMPLE, l, r, 6'($urandom), $urandom);
    endtask

    task automatic send_coef(logic [5:0] idx, logic [31:0] val);
        push_request(sceq_pkg::OPN_COEF, 24'($urandom), 24'($urandom), idx, val);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain: every prediction answered, then let a trailing coefficient request settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic setup(bit hp, bit lp, bit mo, logic [16:0] k);
        drain();
        write_reg(sceq_pkg::CFG_HP_EN, {16'd0, hp});
        write_reg(sceq_pkg::CFG_LP_EN, {16'd0, lp});
        write_reg(sceq_pkg::CFG_MONO, {16'd0, mo});
        write_reg(sceq_pkg::CFG_SMOOTH, k);
    endtask

    // mostly moderate coefficients near the pass-through range, some raw words
    task automatic random_items(int count);
        int          r;
        logic [31:0] val;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 16) begin
                if ($urandom_range(0, 3) == 0) val = $urandom;
                else val = 32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
                if (r < 14) send_coef(6'($urandom_range(0, sceq_pkg::NUM_COEFS - 1)), val);
                else send_coef(6'($urandom_range(sceq_pkg::NUM_COEFS, 63)), val);
            end else begin
                send_sample(24'($urandom), 24'($urandom));
            end
        end
    endtask

    // receiver stalls
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    initial begin
        no_gaps     = 0;
        i_rst_n     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tuser     <= sceq_pkg::OPN_SAMPLE;
        s_tdata     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= sceq_pkg::CFG_HP_EN;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass-through after reset, sample extremes
        send_sample(24'h7fffff, 24'h800000);
        send_sample(24'h800000, 24'h7fffff);
        send_sample(24'h000000, 24'hffffff);
        send_sample(24'h000001, 24'h555555);
        // coefficient extremes, first and last index, ignored indexes
        send_coef(6'd0, 32'h7fffffff);
        send_coef(6'd32, 32'h80000000);
        send_coef(6'd33, 32'h12345678);
        send_coef(6'd63, 32'hffffffff);
        send_sample(24'h7fffff, 24'h800000);
        send_sample(24'h400000, 24'hc00000);
        send_coef(6'd0, 32'h0800_0000);
        send_coef(6'd32, 32'h0000_0000);
        send_coef(6'd4, 32'h0400_0000);
        send_coef(6'd31, 32'hfc00_0000);
        send_sample(24'h123456, 24'hfedcba);

        // instant mixes, mono, then first-sample snap already passed
        setup(1, 1, 1, 17'd65536);
        send_sample(24'h7fffff, 24'h000000);
        send_sample(24'h800000, 24'h7fffff);
        send_sample(24'h2aaaaa, 24'h800000);
        random_items(110);

        // smoothing frozen at zero, mixes held at their earlier values
        setup(0, 0, 0, 17'd0);
        random_items(100);

        // smoothing above unity acts as unity
        setup(0, 1, 0, 17'h1ffff);
        no_gaps = 1;
        random_items(90);
        no_gaps = 0;

        // slowest easing, high-pass toward its filtered path, low-pass toward dry
        setup(1, 0, 1, 17'd1);
        random_items(110);

        setup(1, 1, 0, 17'(sceq_pkg::SMOOTH_RST));
        random_items(110);

        setup(0, 1, 1, 17'($urandom_range(0, 131071)));
        random_items(112);

        drain();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
